[src/rpst_pkg.sv]
// ----------------------------------------------------------------------------
// rpst_pkg
// Shared constants and types for the rotation pulse speed tracker.
// ----------------------------------------------------------------------------
package rpst_pkg;

    // Samples gathered per vote block (3..15)
    localparam int SAMPLES_PER_VOTE = 8;
    // Speed history ring depth, power of two (2..64)
    localparam int SPEED_HISTORY    = 8;
    localparam int TRANS_PER_SPEED  = 4;
    localparam int US_PER_SECOND    = 1000000;

    localparam int SLOT_W  = $clog2(SAMPLES_PER_VOTE + 1);
    localparam int TCNT_W  = $clog2(TRANS_PER_SPEED + 1);
    localparam int HIST_AW = $clog2(SPEED_HISTORY);
    localparam int TIME_W  = 32;
    localparam int TRANS_W = 32;
    localparam int POS_W   = 16;
    localparam int SPEED_W = 30;
    localparam int SUM_W   = SPEED_W + HIST_AW;
    localparam int DCNT_W  = $clog2(SPEED_W);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // 4 transitions * 1e6 us/s * 256 (Q8)
    localparam logic [SPEED_W-1:0] SPEED_NUM =
        SPEED_W'(TRANS_PER_SPEED * US_PER_SECOND * 256);
    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_NUM;

    localparam logic [SLOT_W-1:0] SLOT_VOTE      = SLOT_W'(SAMPLES_PER_VOTE);
    localparam logic [SLOT_W-1:0] VOTE_LOW_MAX   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] VOTE_HIGH_MIN  = SLOT_W'(SAMPLES_PER_VOTE - 1);
    localparam logic [TCNT_W-1:0] TCNT_SPEED     = TCNT_W'(TRANS_PER_SPEED);
    localparam logic [HIST_AW-1:0] HIST_LAST     = HIST_AW'(SPEED_HISTORY - 1);
    localparam logic [POS_W-1:0]  POS_MAX        = '1;

    // Item handed from front to back
    typedef struct packed {
        logic [TRANS_W-1:0] trans;
        logic [POS_W-1:0]   pos;
        logic               speed_req;
        logic [TIME_W-1:0]  dt;
    } rpst_item_t;

endpackage

[src/rotation_pulse_speed_tracker_core.sv]
// ----------------------------------------------------------------------------
// rotation_pulse_speed_tracker_core
// Tachometer: majority vote on sensor pin blocks, transition and position
// counting, speed from an iterative divider, speed history average.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one pin sample item per cycle
//   while in_ready is high, with the ramp flag, direction and microsecond
//   timestamp. Output channel (out_valid/out_ready) returns one result
//   item per input item, in order. The front votes and counts at
//   acceptance and pushes into a 4-entry queue; the back pulls from the
//   queue and drives a registered output. Items that complete every
//   fourth transition need a speed: 1000000*1024/dt on a radix-2
//   divider that runs 30 iterations before the result shows (a zero
//   dt saturates without dividing). Throughput is one item per cycle
//   between speed items while the receiver is ready; while the divider
//   runs the speed item stays at the queue head, the queue absorbs up
//   to three more items, then in_ready drops.
//   Reset clears all counters, the vote, the position, the history ring
//   and its sum. A stalled receiver holds the result; the back stops, the
//   queue fills and in_ready falls, so no item is lost.
// ----------------------------------------------------------------------------
module rotation_pulse_speed_tracker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        pin_level,
    input  logic        power_ramping,
    input  logic        direction_up,
    input  logic [31:0] time_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] transition_count,
    output logic [15:0] position,
    output logic        speed_valid,
    output logic [29:0] speed_q8,
    output logic [29:0] average_speed_q8,
    output logic        history_wrapped
);
    import rpst_pkg::*;

    rpst_item_t front_item;
    rpst_item_t head_item;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       push;

    // Accept whenever the queue has room; the back drains it independently.
    assign in_ready = ~q_full;
    assign push     = in_valid & in_ready;

    rpst_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .pin_level     (pin_level),
        .power_ramping (power_ramping),
        .direction_up  (direction_up),
        .time_us       (time_us),
        .item          (front_item)
    );

    rpst_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: divider, history ring and output register.
    rpst_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head_item),
        .q_empty          (q_empty),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .transition_count (transition_count),
        .position         (position),
        .speed_valid      (speed_valid),
        .speed_q8         (speed_q8),
        .average_speed_q8 (average_speed_q8),
        .history_wrapped  (history_wrapped)
    );

endmodule

[src/rpst_front.sv]
// ----------------------------------------------------------------------------
// rpst_front
// Block voting, transition counting and position tracking; tags items that
// need a speed computation and hands them to the queue.
// ----------------------------------------------------------------------------
module rpst_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        pin_level,
    input  logic                        power_ramping,
    input  logic                        direction_up,
    input  logic [31:0]                 time_us,
    output rpst_pkg::rpst_item_t        item
);
    import rpst_pkg::*;

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  ones_reg, ones_next;
    logic               voted_reg, voted_next;
    logic [TRANS_W-1:0] trans_reg, trans_next;
    logic [TCNT_W-1:0]  since_reg, since_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TIME_W-1:0]  tlast_reg, tlast_next;

    logic [SLOT_W-1:0]  slot_v;
    logic [SLOT_W-1:0]  ones_v;
    logic               step;
    logic [TCNT_W-1:0]  since_sum;
    logic               req;

    always_comb
    begin
        slot_v     = power_ramping ? '0 : slot_reg;
        ones_v     = power_ramping ? '0 : ones_reg;
        slot_next  = slot_v;
        ones_next  = ones_v;
        voted_next = voted_reg;
        step       = 1'b0;
        if (slot_v < SLOT_VOTE)
        begin
            ones_next = ((slot_v == '0) ? '0 : ones_v)
                      + {{(SLOT_W-1){1'b0}}, pin_level};
            slot_next = slot_v + SLOT_W'(1);
        end
        else
        begin
            slot_next = '0;
            ones_next = '0;
            if (ones_v <= VOTE_LOW_MAX)
            begin
                step       = voted_reg;
                voted_next = 1'b0;
            end
            else if (ones_v >= VOTE_HIGH_MIN)
            begin
                step       = ~voted_reg;
                voted_next = 1'b1;
            end
        end

        trans_next = trans_reg;
        pos_next   = pos_reg;
        if (step)
        begin
            trans_next = trans_reg + TRANS_W'(1);
            if (direction_up)
            begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg != '0)
            begin
                pos_next = pos_reg - POS_W'(1);
            end
        end

        since_sum  = since_reg + {{(TCNT_W-1){1'b0}}, step};
        req        = (since_sum >= TCNT_SPEED);
        since_next = req ? '0 : since_sum;
        tlast_next = req ? time_us : tlast_reg;

        item.trans     = trans_next;
        item.pos       = pos_next;
        item.speed_req = req;
        item.dt        = time_us - tlast_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            ones_reg  <= '0;
            voted_reg <= 1'b0;
            trans_reg <= '0;
            since_reg <= '0;
            pos_reg   <= '0;
            tlast_reg <= '0;
        end
        else if (push)
        begin
            slot_reg  <= slot_next;
            ones_reg  <= ones_next;
            voted_reg <= voted_next;
            trans_reg <= trans_next;
            since_reg <= since_next;
            pos_reg   <= pos_next;
            tlast_reg <= tlast_next;
        end
    end

endmodule

[src/rpst_fifo.sv]
// ----------------------------------------------------------------------------
// rpst_fifo
// Short item queue between front and back.
// ----------------------------------------------------------------------------
module rpst_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rpst_pkg::rpst_item_t push_item,
    input  logic                 pop,
    output rpst_pkg::rpst_item_t head,
    output logic                 full,
    output logic                 empty
);
    import rpst_pkg::*;

    rpst_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QPTR_W:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[src/rpst_div.sv]
// ----------------------------------------------------------------------------
// rpst_div
// Radix-2 restoring divider: SPEED_NUM / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rpst_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   divisor,
    output logic                          done,
    output logic [rpst_pkg::SPEED_W-1:0]  quotient
);
    import rpst_pkg::*;

    logic [TIME_W-1:0]  dvs_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [SPEED_W-1:0] quot_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [TIME_W:0]    rem_shift;
    logic               ge;
    logic [TIME_W:0]    rem_sub;
    logic               last;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[SPEED_W-1]};
        ge        = (rem_shift >= {1'b0, dvs_reg});
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        last      = (cnt_reg == DCNT_W'(SPEED_W - 1));
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= SPEED_NUM;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            quot_reg <= {quot_reg[SPEED_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule

[src/rpst_back.sv]
// ----------------------------------------------------------------------------
// rpst_back
// Speed computation, history ring with running sum, and output register.
// ----------------------------------------------------------------------------
module rpst_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rpst_pkg::rpst_item_t          head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   transition_count,
    output logic [15:0]                   position,
    output logic                          speed_valid,
    output logic [29:0]                   speed_q8,
    output logic [29:0]                   average_speed_q8,
    output logic                          history_wrapped
);
    import rpst_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SPEED_W-1:0]  hist_reg [SPEED_HISTORY];
    logic [HIST_AW-1:0]  hslot_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SPEED_W-1:0]  last_reg;
    logic                oval_reg;
    logic [TRANS_W-1:0]  otrans_reg;
    logic [POS_W-1:0]    opos_reg;
    logic                osv_reg;
    logic                owrap_reg;

    logic                out_free;
    logic                commit;
    logic                div_start;
    logic                div_done;
    logic [SPEED_W-1:0]  div_quot;
    logic                dt_zero;
    logic [SPEED_W-1:0]  spd;
    logic [SUM_W-1:0]    sum_next;

    rpst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (head.dt),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        out_free   = ~oval_reg | out_ready;
        dt_zero    = (head.dt == '0);
        commit     = 1'b0;
        div_start  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.speed_req && !dt_zero)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        commit = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        pop      = commit;
        spd      = dt_zero ? SPEED_MAX : div_quot;
        sum_next = sum_reg - SUM_W'(hist_reg[hslot_reg]) + SUM_W'(spd);
    end

    assign out_valid        = oval_reg;
    assign transition_count = otrans_reg;
    assign position         = opos_reg;
    assign speed_valid      = osv_reg;
    assign speed_q8         = last_reg;
    assign average_speed_q8 = sum_reg[SUM_W-1:HIST_AW];
    assign history_wrapped  = owrap_reg;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            otrans_reg <= head.trans;
            opos_reg   <= head.pos;
            osv_reg    <= head.speed_req;
            owrap_reg  <= head.speed_req && (hslot_reg == HIST_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
            hslot_reg <= '0;
            sum_reg   <= '0;
            last_reg  <= '0;
            for (int i = 0; i < SPEED_HISTORY; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                oval_reg <= 1'b1;
            else if (out_ready)
                oval_reg <= 1'b0;
            if (commit && head.speed_req)
            begin
                hist_reg[hslot_reg] <= spd;
                sum_reg             <= sum_next;
                last_reg            <= spd;
                hslot_reg           <= (hslot_reg == HIST_LAST) ? '0
                                       : hslot_reg + HIST_AW'(1);
            end
        end
    end

endmodule

[src/rpst_checker.sv]
// ----------------------------------------------------------------------------
// rpst_checker
// Port-level assertions for the speed tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rpst_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] transition_count,
    input  logic [15:0] position,
    input  logic        speed_valid,
    input  logic [29:0] speed_q8,
    input  logic [29:0] average_speed_q8,
    input  logic        history_wrapped
);
    import rpst_pkg::*;

    // Offered input item waits until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input item withdrawn before acceptance");

    // Stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(transition_count)
            && $stable(position) && $stable(speed_q8))
        else $error("result changed while stalled");

    // A speed is taken every fourth transition
    a_speed_mod4: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && speed_valid |-> transition_count[1:0] == 2'b00)
        else $error("speed not on a fourth transition");

    // Ring wrap only comes with a new speed
    a_wrap_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && history_wrapped |-> speed_valid)
        else $error("wrap without speed");

    // Speeds and their mean stay within saturation
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed_q8 <= SPEED_MAX && average_speed_q8 <= SPEED_MAX)
        else $error("speed beyond saturation");

endmodule

bind rotation_pulse_speed_tracker_core rpst_checker u_rpst_checker (.*);

[tb/tb_rotation_pulse_speed_tracker_core.sv]
// ----------------------------------------------------------------------------
// tb_rotation_pulse_speed_tracker_core
// Self-checking bench for the tachometer core. Pin samples go in as
// well-formed vote blocks with random content, plus ramp restarts and odd
// timestamps. A cycle-free model of the vote, the counters, the speed and
// the history ring predicts every result item, and each one is compared
// field by field in order. Both sides idle at random, and one long output
// stall fills the core and stops its input.
// ----------------------------------------------------------------------------
module tb_rotation_pulse_speed_tracker_core;

    import rpst_pkg::*;

    localparam int ITEM_TARGET = 950;
    localparam int STRETCH     = 100;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 60;
    localparam int MAX_IDLE    = 12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        pin_level;
    logic        power_ramping;
    logic        direction_up;
    logic [31:0] time_us;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] transition_count;
    logic [15:0] position;
    logic        speed_valid;
    logic [29:0] speed_q8;
    logic [29:0] average_speed_q8;
    logic        history_wrapped;

    // One expected result item
    typedef struct {
        logic [31:0] transitions;
        logic [15:0] position;
        logic        speed_valid;
        logic [29:0] speed;
        logic [29:0] average;
        logic        wrapped;
    } tach_reading_t;

    tach_reading_t pending_readings[$];

    // Model state, mirrors the core after reset
    int unsigned     m_slot           = 0;
    int unsigned     m_ones           = 0;
    logic            m_vote           = 1'b0;
    logic [31:0]     m_trans          = '0;
    logic [31:0]     m_trans_at_speed = '0;
    logic [15:0]     m_pos            = '0;
    logic [31:0]     m_time_at_speed  = '0;
    logic [31:0]     m_hist [SPEED_HISTORY] = '{default: '0};
    int unsigned     m_hist_slot      = 0;
    longint unsigned m_hist_sum       = 0;
    logic [31:0]     m_last_speed     = '0;

    // Stimulus and handshake control
    bit          tx_idle        = 1'b0;
    bit          rx_idle        = 1'b0;
    int          rx_stall_left  = 0;
    int          rx_hold_cycles = 0;
    int          up_bias        = 50;
    logic [31:0] cur_time       = '0;
    logic [SAMPLES_PER_VOTE-1:0] block_mask = '0;
    int          items_sent     = 0;
    int          fail_count     = 0;
    int          cycle_count    = 0;

    rotation_pulse_speed_tracker_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pin_level        (pin_level),
        .power_ramping    (power_ramping),
        .direction_up     (direction_up),
        .time_us          (time_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .transition_count (transition_count),
        .position         (position),
        .speed_valid      (speed_valid),
        .speed_q8         (speed_q8),
        .average_speed_q8 (average_speed_q8),
        .history_wrapped  (history_wrapped)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one accepted item to the model state and queues the
    // result item it should produce.
    // ------------------------------------------------------------------------
    task automatic tach_predict(input logic pin, input logic ramp, input logic up,
                                input logic [31:0] now);
        tach_reading_t   r;
        int unsigned     ones;
        bit              counted;
        logic [31:0]     delta;
        logic [31:0]     dt;
        longint unsigned quotient;
        logic [31:0]     speed;
        counted       = 1'b0;
        r.speed_valid = 1'b0;
        r.wrapped     = 1'b0;

        // ramp restarts the block; this item then samples as slot 0
        if (ramp)
        begin
            m_slot = 0;
            m_ones = 0;
        end

        if (m_slot < SAMPLES_PER_VOTE)
        begin
            m_ones = (m_slot == 0 ? 0 : m_ones) + pin;
            m_slot++;
        end
        else
        begin
            // vote item: its own sample is dropped
            ones   = m_ones;
            m_slot = 0;
            m_ones = 0;
            if (ones <= 1)
            begin
                counted = m_vote;
                m_vote  = 1'b0;
            end
            else if (ones >= SAMPLES_PER_VOTE - 1)
            begin
                counted = !m_vote;
                m_vote  = 1'b1;
            end
        end

        if (counted)
        begin
            m_trans++;
            if (up && m_pos != 16'hFFFF)
                m_pos++;
            else if (!up && m_pos != 16'h0000)
                m_pos--;
        end

        delta = m_trans - m_trans_at_speed;
        if (delta >= TRANS_PER_SPEED)
        begin
            dt = now - m_time_at_speed;
            if (dt == 0)
                speed = 32'(SPEED_MAX);
            else
            begin
                quotient = (64'(delta) * 64'(US_PER_SECOND) * 64'd256) / 64'(dt);
                speed    = (quotient > 64'(SPEED_MAX)) ? 32'(SPEED_MAX) : 32'(quotient);
            end
            m_hist_sum            = m_hist_sum - m_hist[m_hist_slot] + speed;
            m_hist[m_hist_slot]   = speed;
            if (m_hist_slot == SPEED_HISTORY - 1)
            begin
                m_hist_slot = 0;
                r.wrapped   = 1'b1;
            end
            else
                m_hist_slot++;
            m_last_speed     = speed;
            m_time_at_speed  = now;
            m_trans_at_speed = m_trans;
            r.speed_valid    = 1'b1;
        end

        r.transitions = m_trans;
        r.position    = m_pos;
        r.speed       = m_last_speed[29:0];
        r.average     = 30'(m_hist_sum / SPEED_HISTORY);
        pending_readings.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Sender: one item per call. Valid stays high across back-to-back items;
    // it only drops when a gap is drawn.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic pin, input logic ramp, input logic up,
                               input logic [31:0] stamp);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        pin_level     <= pin;
        power_ramping <= ramp;
        direction_up  <= up;
        time_us       <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        tach_predict(pin, ramp, up, stamp);
        items_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Random item, shaped from the model state so that most items form full
    // vote blocks. Block ones count is mostly the opposite of the current
    // vote, sometimes at the thresholds, sometimes in the hold band.
    // ------------------------------------------------------------------------
    task automatic send_random_sample();
        logic pin;
        logic ramp;
        logic up;
        int   pick;
        int   k;
        int   left;
        up = ($urandom_range(0, 99) < up_bias);
        if (m_slot >= SAMPLES_PER_VOTE)
        begin
            // vote item: pin is don't-care, timestamp drives the speed math
            pin  = $urandom_range(0, 1);
            ramp = ($urandom_range(0, 11) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 2)
                cur_time = m_time_at_speed;         // zero elapsed time
            else if (pick < 3)
                cur_time = m_time_at_speed + 1;     // smallest nonzero interval
            else if (pick < 5)
                cur_time = $urandom;                // jump, may wrap backwards
            else if (pick < 8)
                cur_time += $urandom_range(1000, 4000000);
            else
                cur_time += $urandom_range(1, 60);
        end
        else
        begin
            if (m_slot == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    k = SAMPLES_PER_VOTE;
                else if (pick < 6)
                    k = SAMPLES_PER_VOTE - 1;
                else if (pick < 8)
                    k = $urandom_range(2, SAMPLES_PER_VOTE - 2);
                else if (pick < 9)
                    k = 1;
                else
                    k = 0;
                if (m_vote)
                    k = SAMPLES_PER_VOTE - k;
                // exactly k ones at random positions
                left = k;
                for (int i = 0; i < SAMPLES_PER_VOTE; i++)
                begin
                    block_mask[i] = ($urandom_range(0, SAMPLES_PER_VOTE - 1 - i) < left);
                    if (block_mask[i])
                        left--;
                end
            end
            pin  = block_mask[m_slot];
            ramp = ($urandom_range(0, 39) == 0);
            cur_time += $urandom_range(1, 60);
        end
        send_sample(pin, ramp, up, cur_time);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Threshold blocks: seven highs vote high, a single high votes low. The
    // vote item carries the opposite pin to show it is ignored. Second
    // transition steps down back to zero.
    task automatic test_vote_thresholds();
        logic [SAMPLES_PER_VOTE-1:0] mostly_high;
        logic [SAMPLES_PER_VOTE-1:0] single_high;
        mostly_high    = '1;
        mostly_high[3] = 1'b0;
        single_high    = '0;
        single_high[4] = 1'b1;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int i = 0; i < SAMPLES_PER_VOTE; i++)
            send_sample(mostly_high[i], 1'b0, 1'b1, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
        send_sample(1'b0, 1'b0, 1'b1, 32'h0000_0010);
        for (int i = 0; i < SAMPLES_PER_VOTE; i++)
            send_sample(single_high[i], 1'b0, 1'b0, 32'h0000_0020 + i);
        send_sample(1'b1, 1'b0, 1'b0, 32'h0000_0040);
        cur_time = 32'h0000_0040;
    endtask

    // Ramp restarts the block mid-way, twice in a row
    task automatic test_ramp_restart();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_sample(1'b1, 1'b0, 1'b1, 32'h0000_0050);
        send_sample(1'b1, 1'b0, 1'b1, 32'h0000_0051);
        send_sample(1'b1, 1'b1, 1'b1, 32'h0000_0052);
        send_sample(1'b0, 1'b1, 1'b0, 32'h0000_0053);
        cur_time = 32'h0000_0053;
    endtask

    // Long output stall while the sender keeps pushing: the queue fills and
    // in_ready must drop without losing any item.
    task automatic test_backpressure();
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        up_bias        = 70;
        rx_hold_cycles = 80;
        repeat (40) send_random_sample();
    endtask

    // Bulk random run in stretches; idling cycles through off, sender only,
    // receiver only, both.
    task automatic test_random_sequences();
        int mode;
        for (int s = 0; items_sent < ITEM_TARGET; s++)
        begin
            mode    = s % 4;
            tx_idle = mode[0];
            rx_idle = mode[1];
            case ($urandom_range(0, 2))
                0:       up_bias = 20;
                1:       up_bias = 50;
                default: up_bias = 80;
            endcase
            repeat (STRETCH) send_random_sample();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: per-item random stall, plus the long hold-off when requested
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_stall_left > 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted result item with the oldest expectation
    always @(posedge clk)
    begin
        tach_reading_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result item with no expectation pending");
                fail_count++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                check_field("transition_count", exp_r.transitions, transition_count);
                check_field("position", 32'(exp_r.position), 32'(position));
                check_field("speed_valid", 32'(exp_r.speed_valid), 32'(speed_valid));
                check_field("speed_q8", 32'(exp_r.speed), 32'(speed_q8));
                check_field("average_speed_q8", 32'(exp_r.average), 32'(average_speed_q8));
                check_field("history_wrapped", 32'(exp_r.wrapped), 32'(history_wrapped));
            end
            rx_stall_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pin_level     = 1'b0;
        power_ramping = 1'b0;
        direction_up  = 1'b0;
        time_us       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_vote_thresholds();
        test_ramp_restart();
        test_backpressure();
        test_random_sequences();

        @(negedge clk);
        in_valid <= 1'b0;
        // divider may still be busy on the last speed item
        wait (pending_readings.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
